[src/vital_sign_packet_deframer_defines.svh]
// assertion macros for the vital sign packet deframer
`ifndef VITAL_SIGN_PACKET_DEFRAMER_DEFINES_SVH
`define VITAL_SIGN_PACKET_DEFRAMER_DEFINES_SVH

// check an implication on every clock edge out of reset
`define VSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check an implication on every clock edge, reset included
`define VSD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/vsd_pkg.sv]
// types and constants shared by the vital sign packet deframer
package vsd_pkg;

	localparam int ECG_PAYLOAD_BYTES = 7;
	localparam int ECG_SAMPLE_BYTES = 6;
	localparam int IDX_W = 3;
	localparam int SUM_W = 18;
	localparam int VALUE_W = 16;
	localparam int DIV3_SHIFT = 18;
	localparam logic [17:0] DIV3_RECIP = 18'd87382;

	localparam logic [IDX_W-1:0] ECG_LAST_IDX = IDX_W'(ECG_PAYLOAD_BYTES - 1);
	localparam logic [IDX_W-1:0] ECG_STORE_LIMIT = IDX_W'(ECG_SAMPLE_BYTES);

	localparam logic [7:0] ID_ECG = 8'h08;
	localparam logic [7:0] ID_SPO2 = 8'h09;
	localparam logic [7:0] ID_BP = 8'h0a;

	typedef enum logic [1:0] {
		KIND_ECG = 2'd0,
		KIND_SPO2 = 2'd1,
		KIND_BP = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HEAD = 4'b0010,
		ST_DATA = 4'b0100,
		ST_CSUM = 4'b1000
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} res_t;

endpackage

[src/vsd_div3.sv]
// signed divide by three, truncating toward zero, by reciprocal multiply
module vsd_div3 import vsd_pkg::*; (
	input  logic signed [SUM_W-1:0]   sum,
	output logic signed [VALUE_W-1:0] avg
);

	localparam int ABS_W = SUM_W - 1;
	localparam int PROD_W = ABS_W + SUM_W;

	logic             neg;
	logic [ABS_W-1:0] abs_v;
	logic [PROD_W-1:0] prod;
	logic [VALUE_W-1:0] quo;

	always_comb begin
		neg = sum[SUM_W-1];
		abs_v = neg ? ABS_W'(-sum) : sum[ABS_W-1:0];
		prod = PROD_W'(abs_v) * PROD_W'(DIV3_RECIP);
		quo = prod[DIV3_SHIFT +: VALUE_W];
		avg = neg ? -quo : quo;
	end

endmodule

[src/vsd_framer.sv]
// framing state machine, payload store and checksum checks
module vsd_framer import vsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output res_t       res
);

	`include "vital_sign_packet_deframer_defines.svh"

	state_t           state_q, state_d, eff_state;
	kind_t            kind_q, kind_d;
	logic [7:0]       head_q, head_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             toggle_q, toggle_d;
	logic [7:0]       payload_q [ECG_SAMPLE_BYTES];
	logic signed [SUM_W-1:0] sum_q, sum_d;
	logic signed [VALUE_W-1:0] avg;

	logic             pay_we;
	logic [IDX_W-1:0] pay_idx;
	logic [7:0]       pay_d;
	logic             sum_we;
	logic             res_valid;
	kind_t            res_kind;
	logic [VALUE_W-1:0] res_value;
	logic signed [VALUE_W-1:0] s0, s1, s2;

	vsd_div3 u_div3 (
		.sum (sum_q),
		.avg (avg)
	);

	always_comb begin
		s0 = {payload_q[0], payload_q[1]};
		s1 = {payload_q[2], payload_q[3]};
		s2 = {payload_q[4], payload_q[5]};
		sum_d = SUM_W'(s0) + SUM_W'(s1) + SUM_W'(s2);
	end

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		head_d = head_q;
		idx_d = idx_q;
		toggle_d = toggle_q;
		pay_we = 1'b0;
		pay_idx = idx_q;
		pay_d = {head_q[idx_q], rx_byte[6:0]};
		sum_we = 1'b0;
		res_valid = 1'b0;
		res_kind = kind_q;
		res_value = '0;
		// an identifier byte always drops the frame in progress
		eff_state = rx_byte[7] ? state_q : ST_IDLE;
		unique case (eff_state)
			ST_IDLE: begin
				state_d = ST_IDLE;
				case (rx_byte)
					ID_ECG, ID_SPO2, ID_BP: begin
						if (rx_byte == ID_ECG) begin
							kind_d = KIND_ECG;
						end else if (rx_byte == ID_SPO2) begin
							kind_d = KIND_SPO2;
						end else begin
							kind_d = KIND_BP;
						end
						head_d = '0;
						idx_d = '0;
						state_d = ST_HEAD;
					end
					default: begin
					end
				endcase
			end
			ST_HEAD: begin
				head_d = rx_byte;
				idx_d = '0;
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (kind_q == KIND_ECG) begin
					pay_we = idx_q < ECG_STORE_LIMIT;
					sum_we = idx_q == ECG_LAST_IDX;
					idx_d = idx_q + IDX_W'(1);
					if (idx_q == ECG_LAST_IDX) begin
						state_d = ST_CSUM;
					end
				end else begin
					pay_we = 1'b1;
					pay_idx = '0;
					pay_d = {head_q[0], rx_byte[6:0]};
					state_d = ST_CSUM;
				end
			end
			ST_CSUM: begin
				if (kind_q == KIND_ECG) begin
					if ({1'b0, rx_byte[6:0]} == sum_q[7:0]) begin
						res_valid = !toggle_q;
						res_kind = KIND_ECG;
						res_value = avg;
						toggle_d = !toggle_q;
					end
				end else if (rx_byte == payload_q[0]) begin
					res_valid = 1'b1;
					res_value = {8'h00, payload_q[0]};
				end
				state_d = ST_IDLE;
				idx_d = '0;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_ECG;
			head_q <= '0;
			idx_q <= '0;
			toggle_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			kind_q <= kind_d;
			head_q <= head_d;
			idx_q <= idx_d;
			toggle_q <= toggle_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ECG_SAMPLE_BYTES; i++) begin
			if (step && pay_we && pay_idx == IDX_W'(i)) begin
				payload_q[i] <= pay_d;
			end
		end
		if (step && sum_we) begin
			sum_q <= sum_d;
		end
	end

	assign res.valid = step && res_valid;
	assign res.item.kind = res_kind;
	assign res.item.value = res_value;

	`VSD_ASSERT(a_res_from_csum, res.valid |-> (state_q == ST_CSUM && rx_byte[7]), "result outside checksum byte")
	`VSD_ASSERT(a_csum_to_idle, (step && state_q == ST_CSUM && rx_byte[7]) |=> state_q == ST_IDLE, "checksum byte did not end the frame")

endmodule

[src/vsd_outbuf.sv]
// two-entry result queue driving the master stream
module vsd_outbuf import vsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  res_t               res,
	output logic               full,
	output logic               tvalid,
	input  logic               tready,
	output logic [VALUE_W-1:0] tdata,
	output logic [1:0]         tuser
);

	`include "vital_sign_packet_deframer_defines.svh"

	logic [1:0] count_q;
	item_t      head_q;
	item_t      tail_q;
	logic       push;
	logic       pop;

	assign push = res.valid;
	assign pop = tvalid && tready;
	assign tvalid = count_q != 2'd0;
	assign full = count_q == 2'd2;
	assign tdata = head_q.value;
	assign tuser = head_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && (count_q == 2'd0 || (count_q == 2'd1 && pop))) begin
			head_q <= res.item;
		end else if (pop && count_q == 2'd2) begin
			head_q <= tail_q;
		end
		if (push && count_q == 2'd1 && !pop) begin
			tail_q <= res.item;
		end
	end

	`VSD_ASSERT(a_no_overflow, push |-> !full, "result transfer into a full queue")

endmodule

[src/vital_sign_packet_deframer.sv]
// top level of the vital sign packet deframer
//
// s_axis carries one received byte per transfer. A byte with bit 7 clear is
// a packet identifier (ECG, SpO2 or blood pressure) and drops any partial
// frame. m_axis carries one result per valid frame: tuser is the kind, tdata
// the ECG three-sample average (every second valid ECG frame, the first one
// included) or the SpO2 / blood-pressure byte.
// Throughput: one byte per cycle, sustained while m_axis keeps up.
// The byte sits in an input register, the framer works on it there and any
// result goes into a two-entry output queue whose registered count drives
// m_axis_tvalid; the ECG sum is registered one byte ahead of the checksum
// byte, so the average is one multiply behind that register.
// Reset clears framing state, the decimation toggle and the queue; the
// first byte after reset is expected to be an identifier.
// When the receiver stalls, the queue fills; with both entries full the
// input register holds and s_axis_tready drops until a transfer drains.
module vital_sign_packet_deframer import vsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // rx_byte[7:0]
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [VALUE_W-1:0] m_axis_tdata,   // result_value[15:0], signed
	output logic [1:0]         m_axis_tuser    // result_kind[1:0]
);

	`include "vital_sign_packet_deframer_defines.svh"

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       full;
	logic       advance;
	res_t       res;

	assign advance = valid_s1 && !full;
	assign s_axis_tready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	vsd_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	vsd_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.full   (full),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata),
		.tuser  (m_axis_tuser)
	);

	`VSD_ASSERT(a_s1_hold, (valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)), "stalled input byte lost")

endmodule

[tb/tb_vital_sign_packet_deframer.sv]
// testbench for the vital sign packet deframer: framed byte stimulus checked against a predictor
`timescale 1ns / 100ps

module tb_vital_sign_packet_deframer import vsd_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 1000;
	localparam int TAIL_CYCLES = 20;
	localparam int RANDOM_BYTES = 1000;
	localparam int PRESSURE_FRAMES = 40;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;   // rx_byte[7:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [VALUE_W-1:0] m_axis_tdata;   // result_value[15:0], signed
	logic [1:0]         m_axis_tuser;   // result_kind[1:0]

	class deframer_scoreboard;
		state_t           frame_st;
		kind_t            pkt_kind;
		logic [7:0]       head;
		logic [IDX_W-1:0] data_idx;
		logic [7:0]       data_bytes [ECG_PAYLOAD_BYTES];
		bit               skip_next_ecg;
		item_t            due_results [$];
		int               errors;

		function new();
			pkt_kind = KIND_ECG;
			head = '0;
			skip_next_ecg = 1'b0;
			errors = 0;
			end_frame();
		endfunction

		function void report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endfunction

		function void end_frame();
			frame_st = ST_IDLE;
			data_idx = '0;
			foreach (data_bytes[i])
				data_bytes[i] = '0;
		endfunction

		// advance the framing state by one accepted byte, queue any result it yields
		function void accept_rx_byte(logic [7:0] b);
			logic signed [15:0] s0, s1, s2;
			int                 sum;
			item_t              res;
			if (!b[7])
				frame_st = ST_IDLE;
			case (frame_st)
				ST_IDLE: begin
					if (b == ID_ECG || b == ID_SPO2 || b == ID_BP) begin
						if (b == ID_ECG)
							pkt_kind = KIND_ECG;
						else if (b == ID_SPO2)
							pkt_kind = KIND_SPO2;
						else
							pkt_kind = KIND_BP;
						head = '0;
						data_idx = '0;
						frame_st = ST_HEAD;
					end
				end
				ST_HEAD: begin
					head = b;
					data_idx = '0;
					frame_st = ST_DATA;
				end
				ST_DATA: begin
					if (pkt_kind == KIND_ECG) begin
						data_bytes[data_idx] = {head[data_idx], b[6:0]};
						if (data_idx == ECG_LAST_IDX)
							frame_st = ST_CSUM;
						else
							data_idx = data_idx + 1'b1;
					end else begin
						data_bytes[0] = {head[0], b[6:0]};
						frame_st = ST_CSUM;
					end
				end
				default: begin
					if (pkt_kind == KIND_ECG) begin
						s0 = {data_bytes[0], data_bytes[1]};
						s1 = {data_bytes[2], data_bytes[3]};
						s2 = {data_bytes[4], data_bytes[5]};
						sum = int'(s0) + int'(s1) + int'(s2);
						if ({1'b0, b[6:0]} == sum[7:0]) begin
							if (!skip_next_ecg) begin
								res.kind = KIND_ECG;
								res.value = 16'(sum / 3);
								due_results.push_back(res);
							end
							skip_next_ecg = !skip_next_ecg;
						end
					end else if (b == data_bytes[0]) begin
						res.kind = pkt_kind;
						res.value = {8'h00, data_bytes[0]};
						due_results.push_back(res);
					end
					end_frame();
				end
			endcase
		endfunction

		function void check_result(logic [1:0] kind_seen, logic [VALUE_W-1:0] value_seen);
			item_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d value %0d", kind_seen,
					$signed(value_seen)));
			end else begin
				want = due_results.pop_front();
				if (kind_seen !== want.kind)
					report($sformatf("kind %0d, expected %0d", kind_seen, want.kind));
				if (value_seen !== want.value)
					report($sformatf("value %0d, expected %0d", $signed(value_seen),
						$signed(want.value)));
			end
		endfunction
	endclass

	deframer_scoreboard sb;
	logic [7:0]         stim_q [$];
	int                 frame_bytes;
	int                 burst_left;
	int                 hold_request;
	int                 idle_cycles;

	vital_sign_packet_deframer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// ecg frame; a good one gets its third sample nudged so the checksum can match
	task automatic push_ecg(input logic signed [15:0] s0, s1, s2, input bit good);
		logic [7:0] p [ECG_PAYLOAD_BYTES];
		logic [7:0] hd;
		int         sum;
		sum = int'(s0) + int'(s1) + int'(s2);
		if (good && sum[7]) begin
			s2 = s2 - 16'sd128;
			sum = int'(s0) + int'(s1) + int'(s2);
		end
		p[0] = s0[15:8];
		p[1] = s0[7:0];
		p[2] = s1[15:8];
		p[3] = s1[7:0];
		p[4] = s2[15:8];
		p[5] = s2[7:0];
		p[6] = 8'($urandom);
		hd[7] = 1'b1;
		for (int i = 0; i < ECG_PAYLOAD_BYTES; i++)
			hd[i] = p[i][7];
		stim_q.push_back(ID_ECG);
		stim_q.push_back(hd);
		for (int i = 0; i < ECG_PAYLOAD_BYTES; i++)
			stim_q.push_back({1'b1, p[i][6:0]});
		if (good || $urandom_range(0, 1))
			stim_q.push_back({1'b1, sum[6:0]});
		else
			stim_q.push_back({1'b1, 7'($urandom)});
		frame_bytes += ECG_PAYLOAD_BYTES + 3;
	endtask

	// spo2 or bp frame; a match needs head bit 0 set since the checksum byte has bit 7 set
	task automatic push_single(input logic [7:0] id, input bit good);
		logic [7:0] hd;
		logic [6:0] d;
		hd = {1'b1, 7'($urandom)};
		d = 7'($urandom);
		if (good)
			hd[0] = 1'b1;
		stim_q.push_back(id);
		stim_q.push_back(hd);
		stim_q.push_back({1'b1, d});
		stim_q.push_back(good ? {1'b1, d} : {1'b1, 7'($urandom)});
		frame_bytes += 4;
	endtask

	function automatic logic [7:0] pick_id();
		case ($urandom_range(0, 2))
			0: return ID_ECG;
			1: return ID_SPO2;
			default: return ID_BP;
		endcase
	endfunction

	task automatic gen_frame();
		int r;
		int cut;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			push_ecg(pick_sample(), pick_sample(), pick_sample(), $urandom_range(0, 3) != 0);
		end else if (r < 80) begin
			push_single($urandom_range(0, 1) ? ID_SPO2 : ID_BP, $urandom_range(0, 3) != 0);
		end else if (r < 90) begin
			// random-length frame, cut short by whatever comes next unless its bytes complete it
			stim_q.push_back(pick_id());
			cut = $urandom_range(0, 5);
			repeat (cut)
				stim_q.push_back({1'b1, 7'($urandom)});
			frame_bytes += cut + 1;
		end else begin
			stim_q.push_back(8'($urandom));
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.accept_rx_byte(b);
	endtask

	task automatic send_queue();
		while (stim_q.size() != 0)
			send_byte(stim_q.pop_front());
	endtask

	task automatic run_random(input int target);
		frame_bytes = 0;
		while (frame_bytes < target) begin
			gen_frame();
			send_queue();
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver stall pattern, plus a long hold-off on request
	initial begin
		int  hold_left;
		int  run_left;
		bit  level;
		m_axis_tready = 1'b0;
		hold_left = 0;
		run_left = 0;
		level = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else begin
				if (run_left == 0) begin
					level = $urandom_range(0, 2) != 0;
					run_left = level ? $urandom_range(1, 60) : $urandom_range(1, 15);
				end
				run_left--;
				m_axis_tready = level;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int drain_cycles;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		burst_left = 0;
		hold_request = 0;
		frame_bytes = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unknown id, idle byte, ecg cut by a bp frame, min ecg, max spo2
		stim_q = {8'h7f, 8'hff, ID_ECG, 8'h80, 8'h85, ID_BP, 8'h81, 8'h80, 8'h80};
		push_ecg(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
		stim_q = {stim_q, ID_SPO2, 8'hff, 8'hff, 8'hff};
		send_queue();
		wait_drain();

		run_random(RANDOM_BYTES);

		// fill the output queue while the receiver holds off
		hold_request = HOLD_CYCLES;
		repeat (PRESSURE_FRAMES)
			push_single($urandom_range(0, 1) ? ID_SPO2 : ID_BP, 1'b1);
		send_queue();
		wait_drain();

		run_random(RANDOM_BYTES);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		drain_cycles = 0;
		while (sb.due_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.due_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/vsd_pkg.sv
src/vsd_div3.sv
src/vsd_framer.sv
src/vsd_outbuf.sv
src/vital_sign_packet_deframer.sv
tb/tb_vital_sign_packet_deframer.sv
